// ===== sv/dgm_pkg.sv =====
// Shared constants, command/status types and state types for the digamma unit.
`timescale 1ns / 1ps
package dgm_pkg;

   // Default fraction bits of the argument and result
   localparam int DGM_FRAC_BITS = 16;

   // Series and offset constants in Q.32, rounded to nearest
   localparam logic [63:0] D1_WIDE = ((64'd5772156649 << 22) + 64'd4882812) / 64'd9765625;
   localparam logic [63:0] S3_WIDE = ((64'd8333333333 << 21) + 64'd24414062) / 64'd48828125;
   localparam logic [63:0] S4_WIDE =
      ((64'd83333333333 << 19) + 64'd610351562) / 64'd1220703125;
   localparam logic [63:0] S5_WIDE = ((64'd3968253968 << 20) + 64'd122070312) / 64'd244140625;
   localparam logic [31:0] D1_G  = D1_WIDE[31:0];
   localparam logic [31:0] S3_G  = S3_WIDE[31:0];
   localparam logic [31:0] S4_G  = S4_WIDE[31:0];
   localparam logic [31:0] S5_G  = S5_WIDE[31:0];
   localparam logic [31:0] LN2_G = 32'd2977044472;
   localparam logic [63:0] HALF_G = 64'd2147483648;

   // Series multiply operations
   typedef enum logic [1:0] {
      SER_R2,
      SER_T5,
      SER_T4,
      SER_T3
   } ser_op_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASS,
      ST_SMALL_WAIT,
      ST_STEP_CHK,
      ST_STEP_WAIT,
      ST_LAST_WAIT,
      ST_LOG_WAIT,
      ST_SER_R2,
      ST_SER_T5,
      ST_SER_T4,
      ST_SER_T3,
      ST_SER_ACC,
      ST_ROUND
   } ctrl_state_type;

   // Log unit states
   typedef enum logic [2:0] {
      LG_IDLE,
      LG_NORM,
      LG_SQ,
      LG_FRAC,
      LG_SUM
   } log_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       div_go;
      logic       div_sel_y;
      logic       small_acc;
      logic       step_acc;
      logic       last_cap;
      logic       log_acc;
      logic       ser_go;
      ser_op_type ser_op;
      logic       ser_acc;
      logic       publish;
   } dgm_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_zero;
      logic is_small;
      logic y_below;
      logic div_done;
      logic log_done;
   } dgm_sts_type;

endpackage

// ===== sv/dgm_div.sv =====
// Bit-serial restoring divider producing round(2^(F+32)/m).
`timescale 1ns / 1ps
module dgm_div
   import dgm_pkg::*;
#(
   parameter int FRAC_BITS = DGM_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [31:0]            divisor,
   output logic                   done,
   output logic [FRAC_BITS+32:0]  quot
);
   localparam int QW = FRAC_BITS + 33;
   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0] num_ff, num_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [32:0]   trial;
   logic          fits;

   // One quotient bit per cycle
   assign trial = {rem_ff, num_ff[QW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         num_in  = (QW'(1) << (QW - 1)) + QW'(divisor >> 1);
         quot_in = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = {num_ff[QW-2:0], 1'b0};
         quot_in = {quot_ff[QW-2:0], fits};
         rem_in  = fits ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

// ===== sv/dgm_log.sv =====
// Natural log unit in Q.32 by normalization and repeated squaring.
`timescale 1ns / 1ps
module dgm_log
   import dgm_pkg::*;
#(
   parameter int FRAC_BITS = DGM_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [31:0]        y,
   output logic               done,
   output logic signed [63:0] ln
);
   log_state_type state_ff, state_in;
   logic [31:0]        norm_ff;
   logic [4:0]         sh_ff;
   logic [30:0]        m_ff;
   logic [31:0]        frac_ff;
   logic [4:0]         cnt_ff;
   logic [31:0]        fterm_ff;
   logic signed [63:0] ln_ff;
   logic               done_ff;
   logic [61:0]        sq;
   logic [31:0]        sq_top;
   logic [63:0]        fprod;
   logic signed [6:0]  expo;
   logic signed [63:0] ipart;

   assign sq     = 62'(m_ff) * 62'(m_ff);
   assign sq_top = sq[61:30];
   assign fprod  = 64'(frac_ff) * 64'(LN2_G) + HALF_G;
   assign expo   = 7'(31 - int'(sh_ff) - FRAC_BITS);
   assign ipart  = 64'(expo) * $signed({32'b0, LN2_G});

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LG_IDLE: if (go) state_in = LG_NORM;
         LG_NORM: if (norm_ff[31]) state_in = LG_SQ;
         LG_SQ:   if (cnt_ff == 5'd31) state_in = LG_FRAC;
         LG_FRAC: state_in = LG_SUM;
         LG_SUM:  state_in = LG_IDLE;
         default: state_in = LG_IDLE;
      endcase
   end

   // Data path of the log unit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == LG_SUM);
      end
      case (state_ff)
         LG_IDLE: begin
            norm_ff <= y;
            sh_ff   <= '0;
         end
         LG_NORM: begin
            if (norm_ff[31]) begin
               m_ff    <= norm_ff[31:1];
               cnt_ff  <= '0;
               frac_ff <= '0;
            end else begin
               norm_ff <= {norm_ff[30:0], 1'b0};
               sh_ff   <= sh_ff + 5'd1;
            end
         end
         LG_SQ: begin
            m_ff    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
            frac_ff <= {frac_ff[30:0], sq_top[31]};
            cnt_ff  <= cnt_ff + 5'd1;
         end
         LG_FRAC: fterm_ff <= fprod[63:32];
         LG_SUM:  ln_ff <= ipart + 64'(fterm_ff);
         default: ;
      endcase
   end

   assign done = done_ff;
   assign ln   = ln_ff;
endmodule

// ===== sv/dgm_dp.sv =====
// Datapath: argument, stepped value, accumulator, series and result registers.
`timescale 1ns / 1ps
module dgm_dp
   import dgm_pkg::*;
#(
   parameter int FRAC_BITS = DGM_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [31:0] req_arg,
   input  dgm_cmd_type        cmd,
   output dgm_sts_type        sts,
   output logic signed [31:0] rsp_psi,
   output logic               rsp_saturated
);
   localparam int SMALL_QI = (1 << FRAC_BITS) / 100000;
   localparam logic signed [31:0] SMALL_Q = 32'(SMALL_QI);
   localparam logic [31:0] STEP_END = 32'(17 * (1 << (FRAC_BITS - 1)));
   localparam logic [31:0] ONE_Q = 32'(1 << FRAC_BITS);
   localparam int SHIFT = 32 - FRAC_BITS;

   logic signed [31:0] x_ff;
   logic [31:0]        y_ff;
   logic signed [63:0] acc_ff;
   logic [31:0]        r_ff, r2_ff, t_ff;
   logic signed [31:0] psi_ff;
   logic               sat_ff;
   logic [31:0]        mag;
   logic               div_done;
   logic [FRAC_BITS+32:0] div_q;
   logic signed [63:0] q64;
   logic               log_done;
   logic signed [63:0] ln;
   logic [31:0]        ma, mb;
   logic [63:0]        prod;
   logic [31:0]        mres;
   logic signed [63:0] rnd_u, rnd_q;

   assign mag = x_ff[31] ? 32'(-x_ff) : x_ff;
   assign q64 = $signed(64'(div_q));

   dgm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock  (clock),
      .reset  (reset),
      .go     (cmd.div_go),
      .divisor(cmd.div_sel_y ? y_ff : mag),
      .done   (div_done),
      .quot   (div_q)
   );

   dgm_log #(.FRAC_BITS(FRAC_BITS)) u_log (
      .clock(clock),
      .reset(reset),
      .go   (cmd.last_cap),
      .y    (y_ff),
      .done (log_done),
      .ln   (ln)
   );

   // Select series multiplier operands
   always_comb begin
      case (cmd.ser_op)
         SER_R2:  begin ma = r_ff;  mb = r_ff;        end
         SER_T5:  begin ma = S5_G;  mb = r2_ff;       end
         SER_T4:  begin ma = r2_ff; mb = S4_G - t_ff; end
         SER_T3:  begin ma = r2_ff; mb = S3_G - t_ff; end
         default: begin ma = r_ff;  mb = r_ff;        end
      endcase
   end
   assign prod = 64'(ma) * 64'(mb) + HALF_G;
   assign mres = prod[63:32];

   // Round half up to output format
   assign rnd_u = acc_ff + (64'sd1 <<< (SHIFT - 1));
   assign rnd_q = rnd_u >>> SHIFT;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= req_arg;
         y_ff   <= req_arg;
         acc_ff <= '0;
      end
      if (cmd.small_acc)
         acc_ff <= -$signed(64'(D1_G)) + (x_ff[31] ? q64 : -q64);
      if (cmd.step_acc) begin
         acc_ff <= acc_ff - q64;
         y_ff   <= y_ff + ONE_Q;
      end
      if (cmd.last_cap) r_ff <= div_q[31:0];
      if (cmd.log_acc) acc_ff <= acc_ff + ln - $signed(64'(r_ff >> 1));
      if (cmd.ser_go) begin
         if (cmd.ser_op == SER_R2) r2_ff <= mres;
         else t_ff <= mres;
      end
      if (cmd.ser_acc) acc_ff <= acc_ff - $signed(64'(t_ff));
      // Hold the result for the output transfer
      if (cmd.publish) begin
         if (x_ff == 32'sd0) begin
            psi_ff <= 32'sh80000000;
            sat_ff <= 1'b1;
         end else if (rnd_q > 64'sd2147483647) begin
            psi_ff <= 32'sh7FFFFFFF;
            sat_ff <= 1'b1;
         end else if (rnd_q < -64'sd2147483648) begin
            psi_ff <= 32'sh80000000;
            sat_ff <= 1'b1;
         end else begin
            psi_ff <= rnd_q[31:0];
            sat_ff <= 1'b0;
         end
      end
   end

   assign sts.is_zero  = (x_ff == 32'sd0);
   assign sts.is_small = (x_ff <= SMALL_Q);
   assign sts.y_below  = (y_ff < STEP_END);
   assign sts.div_done = div_done;
   assign sts.log_done = log_done;
   assign rsp_psi       = psi_ff;
   assign rsp_saturated = sat_ff;
endmodule

// ===== sv/dgm_ctrl.sv =====
// Controller: sequences classification, stepping, log and series per item.
`timescale 1ns / 1ps
module dgm_ctrl
   import dgm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dgm_sts_type sts,
   output dgm_cmd_type cmd
);
   ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_CLASS;
         ST_CLASS: begin
            if (sts.is_zero) state_in = ST_ROUND;
            else if (sts.is_small) state_in = ST_SMALL_WAIT;
            else state_in = ST_STEP_CHK;
         end
         ST_SMALL_WAIT: if (sts.div_done) state_in = ST_ROUND;
         ST_STEP_CHK:   state_in = sts.y_below ? ST_STEP_WAIT : ST_LAST_WAIT;
         ST_STEP_WAIT:  if (sts.div_done) state_in = ST_STEP_CHK;
         ST_LAST_WAIT:  if (sts.div_done) state_in = ST_LOG_WAIT;
         ST_LOG_WAIT:   if (sts.log_done) state_in = ST_SER_R2;
         ST_SER_R2:     state_in = ST_SER_T5;
         ST_SER_T5:     state_in = ST_SER_T4;
         ST_SER_T4:     state_in = ST_SER_T3;
         ST_SER_T3:     state_in = ST_SER_ACC;
         ST_SER_ACC:    state_in = ST_ROUND;
         ST_ROUND:      if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      cmd.ser_op = SER_R2;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_CLASS: cmd.div_go = !sts.is_zero && sts.is_small;
         ST_SMALL_WAIT: cmd.small_acc = sts.div_done;
         ST_STEP_CHK: begin
            cmd.div_go    = 1'b1;
            cmd.div_sel_y = 1'b1;
         end
         ST_STEP_WAIT: cmd.step_acc = sts.div_done;
         ST_LAST_WAIT: cmd.last_cap = sts.div_done;
         ST_LOG_WAIT:  cmd.log_acc  = sts.log_done;
         ST_SER_R2: begin
            cmd.ser_go = 1'b1;
            cmd.ser_op = SER_R2;
         end
         ST_SER_T5: begin
            cmd.ser_go = 1'b1;
            cmd.ser_op = SER_T5;
         end
         ST_SER_T4: begin
            cmd.ser_go = 1'b1;
            cmd.ser_op = SER_T4;
         end
         ST_SER_T3: begin
            cmd.ser_go = 1'b1;
            cmd.ser_op = SER_T3;
         end
         ST_SER_ACC: cmd.ser_acc = 1'b1;
         ST_ROUND:   cmd.publish = out_free;
         default: ;
      endcase
   end

   // Output valid: set on publish, drop after transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== sv/digamma_fixed_point_unit.sv =====
// Top level of the fixed-point digamma unit.
`timescale 1ns / 1ps
// Computes psi(x) of a signed Q16.16 argument (fraction bits set by FRAC_BITS) and returns a
// saturated result with a flag. One item is worked at a time; the next is accepted while the
// previous result still waits on the output register. A zero argument goes straight to the
// result. Other arguments at or below the small threshold take one reciprocal from the
// bit-serial divider. Larger arguments take one reciprocal per unit step that brings x up to
// 8.5 (none for x >= 8.5, at most 9 steps), a reciprocal of the stepped value, the log unit
// (normalize, repeated squaring, sum) and the series. A result stalled on the output holds
// back the next item's result until it is taken.
module digamma_fixed_point_unit
   import dgm_pkg::*;
#(
   parameter int FRAC_BITS = DGM_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_arg,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_psi,
   output logic               rsp_saturated
);
   dgm_cmd_type cmd;
   dgm_sts_type sts;

   dgm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   dgm_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_arg      (req_arg),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_psi      (rsp_psi),
      .rsp_saturated(rsp_saturated)
   );

`ifndef SYNTHESIS
   // One item at a time: an input transfer closes the input side
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while an item is in progress");

   // A saturated result sits at one of the range limits
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_psi == 32'sh80000000 || rsp_psi == 32'sh7FFFFFFF))
      else $error("saturation flag without clipped value");

   // The divider never finishes in the cycle after its start
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      cmd.div_go |=> !sts.div_done)
      else $error("divider finished too early");
`endif
endmodule

// ===== sim/digamma_fixed_point_unit_test.sv =====
// Self-checking testbench for the fixed-point digamma unit.
`timescale 1ns / 1ps
module digamma_fixed_point_unit_test;
   import dgm_pkg::*;

   localparam int FB = DGM_FRAC_BITS;
   localparam longint unsigned STEP_LIMIT = 64'd17 << (FB - 1);
   localparam longint unsigned ONE_FX = 64'd1 << FB;
   localparam longint SMALL_FX = longint'((64'd1 << FB) / 64'd100000);

   typedef struct {
      logic [31:0] psi;
      logic        sat;
   } psi_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_arg;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_psi;
   logic               rsp_saturated;

   psi_result_type psi_pending[$];
   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int arg_count;
   int result_count;
   int sat_count;

   digamma_fixed_point_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_arg(req_arg),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_psi(rsp_psi),
      .rsp_saturated(rsp_saturated)
   );

   // Generate clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Rounded reciprocal with 32 extra fraction bits
   function automatic longint unsigned recip_fx(input longint unsigned m);
      if (m == 0) return 0;
      return ((64'd1 << (FB + 32)) + (m >> 1)) / m;
   endfunction

   // Rounded Q.32 product
   function automatic longint unsigned mul_fx(input longint unsigned a, input longint unsigned b);
      return (a * b + HALF_G) >> 32;
   endfunction

   // Natural log in Q.32 by leading one and mantissa squaring
   function automatic longint log_fx(input longint unsigned y);
      int lead;
      longint unsigned mant;
      longint unsigned frac;
      longint unsigned bitv;
      lead = 0;
      frac = 0;
      if (y == 0) return 0;
      for (int i = 0; i < 64; i++)
         if (y[i]) lead = i;
      if (lead <= 30) mant = y << (30 - lead);
      else mant = y >> (lead - 30);
      bitv = 64'd1 << 31;
      for (int i = 0; i < 32; i++) begin
         mant = (mant * mant) >> 30;
         if (mant >= (64'd1 << 31)) begin
            frac |= bitv;
            mant >>= 1;
         end
         bitv >>= 1;
      end
      return longint'(lead - FB) * longint'(LN2_G)
         + longint'((frac * longint'(LN2_G) + HALF_G) >> 32);
   endfunction

   // Expected digamma and saturation flag for one argument
   function automatic psi_result_type predict_psi(input logic signed [31:0] arg);
      psi_result_type res;
      longint x;
      longint acc;
      longint q;
      longint unsigned y;
      longint unsigned r;
      longint unsigned r2;
      longint unsigned t;
      x = arg;
      res.sat = 1'b0;
      if (x == 0) begin
         res.psi = 32'h8000_0000;
         res.sat = 1'b1;
         return res;
      end
      if (x <= SMALL_FX) begin
         r = recip_fx(x < 0 ? longint'(-x) : x);
         acc = -longint'(D1_G) + (x < 0 ? longint'(r) : -longint'(r));
      end else begin
         y = x;
         acc = 0;
         while (y < STEP_LIMIT) begin
            acc -= longint'(recip_fx(y));
            y += ONE_FX;
         end
         r = recip_fx(y);
         acc += log_fx(y) - longint'(r >> 1);
         r2 = mul_fx(r, r);
         t = mul_fx(longint'(S5_G), r2);
         t = longint'(S4_G) - t;
         t = mul_fx(r2, t);
         t = longint'(S3_G) - t;
         t = mul_fx(r2, t);
         acc -= longint'(t);
      end
      // Round half up to the output format, then clip
      q = (acc + (64'sd1 <<< (31 - FB))) >>> (32 - FB);
      if (q > 64'sh7FFF_FFFF) begin
         q = 64'sh7FFF_FFFF;
         res.sat = 1'b1;
      end
      if (q < -64'sh8000_0000) begin
         q = -64'sh8000_0000;
         res.sat = 1'b1;
      end
      res.psi = q[31:0];
      return res;
   endfunction

   // Send one argument; called at a falling edge, returns at a falling edge
   task automatic send_arg(input logic [31:0] arg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_arg <= arg;
      do @(posedge clock); while (req_stall);
      psi_pending.push_back(predict_psi(arg));
      arg_count++;
      @(negedge clock);
   endtask

   // Random argument biased toward the stepping range and small negatives
   function automatic logic [31:0] random_arg();
      case ($urandom_range(9))
         0, 1, 2: return $urandom;
         3, 4: return $urandom_range(32'h0009_0000, 1);
         5: return $urandom_range(32'h0000_0400, 0);
         6: return -$urandom_range(32'h0009_0000, 0);
         7: return $urandom_range(32'h7FFF_FFFF, 32'h0008_0000);
         8: return 32'h8000_0000 | $urandom_range(32'hFF);
         default: return (32'h1 << $urandom_range(31)) ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 0);
      endcase
   endfunction

   // Drive receiver stall
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin
      psi_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (psi_pending.size() == 0) begin
            $display("%0t: unexpected result psi=%h saturated=%b", $time, rsp_psi,
               rsp_saturated);
            error_count++;
         end else begin
            exp_res = psi_pending.pop_front();
            if (rsp_saturated) sat_count++;
            if (rsp_psi !== exp_res.psi) begin
               $display("%0t: psi expected %h actual %h", $time, exp_res.psi, rsp_psi);
               error_count++;
            end
            if (rsp_saturated !== exp_res.sat) begin
               $display("%0t: saturated expected %b actual %b", $time, exp_res.sat,
                  rsp_saturated);
               error_count++;
            end
         end
      end
   end

   // Hold until every expected result has arrived
   task automatic wait_drained();
      while (psi_pending.size() != 0) @(negedge clock);
   endtask

   // Extremes, zero, tiny values and the step boundary
   task automatic test_directed();
      logic [31:0] args[$];
      args = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000,
         32'h0008_8000, 32'h0008_7FFF, 32'h0008_8001, 32'h0000_FFFF, 32'h0002_0000,
         32'hFFFE_0000, 32'h0000_0002, 32'hFFFF_FFFE, 32'h4000_0000, 32'h0000_000B,
         32'h0123_4567, 32'hFEDC_BA98, 32'h0007_8000, 32'h7FFF_0000};
      foreach (args[i]) send_arg(args[i]);
   endtask

   // Random arguments under one idling pattern
   task automatic test_random(input int count, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < count; i++) send_arg(random_arg());
   endtask

   // Pause the sender until the block is empty, then resume
   task automatic test_drain_pause();
      for (int i = 0; i < 4; i++) send_arg(random_arg());
      req_valid <= 1'b0;
      wait_drained();
      @(negedge clock);
      for (int i = 0; i < 4; i++) send_arg(random_arg());
   endtask

   // Main sequence
   initial begin
      req_valid = 1'b0;
      req_arg = '0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      error_count = 0;
      arg_count = 0;
      result_count = 0;
      sat_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random(520, 18, 55);
      test_drain_pause();
      test_random(520, 55, 18);
      test_random(520, 0, 0);
      req_valid <= 1'b0;
      wait_drained();
      repeat (200) @(negedge clock);

      $display("Covered %0d arguments (directed extremes, stepping range, negatives),",
         arg_count);
      $display("checked %0d results, %0d of them saturated.", result_count, sat_count);
      if (error_count == 0 && psi_pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // End the run if it hangs
   initial begin
      #200ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/dgm_pkg.sv
sv/dgm_div.sv
sv/dgm_log.sv
sv/dgm_dp.sv
sv/dgm_ctrl.sv
sv/digamma_fixed_point_unit.sv
sim/digamma_fixed_point_unit_test.sv
